@@ hw/rtl/qemr_pkg.sv @@
// qemr_pkg: shared types and constants for the quadrature encoder mouse report unit
// no dependencies; imported by all qemr modules
`default_nettype none
package qemr_pkg;

    localparam int ACCUM_WIDTH_DEF = 16;
    localparam int LIMIT_WIDTH     = 8;
    localparam int GAIN_WIDTH      = 4;
    localparam int MOVE_WIDTH      = 13;
    localparam int CLAMP_WIDTH     = LIMIT_WIDTH + 1;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH  = 8;
    localparam int S_DATA_WIDTH    = 16;
    localparam int M_DATA_WIDTH    = 48;

    localparam logic [LIMIT_WIDTH-1:0] ACCEL_LIMIT_RST  = 8'd150;
    localparam logic [GAIN_WIDTH-1:0]  POINTER_GAIN_RST = 4'd4;
    localparam logic [GAIN_WIDTH-1:0]  WHEEL_GAIN_RST   = 4'd1;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ACCEL_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_POINTER_GAIN = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WHEEL_GAIN   = 2'd2;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] limit;
        logic [GAIN_WIDTH-1:0]  gain;
    } shape_cfg_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } lane_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/qemr_lane.sv @@
// qemr_lane: one quadrature decoder lane with stored pin levels and saturating step count
// depends on qemr_pkg
`default_nettype none
module qemr_lane
    import qemr_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lane_ctrl_t                    ctrl,
    input  wire logic                          pin_a,
    input  wire logic                          pin_b,
    output      logic signed [ACCUM_WIDTH-1:0] count
);

    localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

    logic                          a_reg, a_next;
    logic                          b_reg, b_next;
    logic signed [ACCUM_WIDTH-1:0] acc_reg, acc_next;
    logic signed [ACCUM_WIDTH-1:0] acc_step1, acc_step2;
    logic                          inc, dec;

    always_comb begin
        inc = (pin_a != a_reg) && pin_a && !b_reg;
        // b edge is judged against the already updated a level
        dec = (pin_b != b_reg) && pin_b && !pin_a;
        acc_step1 = (inc && acc_reg != ACC_MAX) ? acc_reg + 1'b1 : acc_reg;
        acc_step2 = (dec && acc_step1 != ACC_MIN) ? acc_step1 - 1'b1 : acc_step1;
        count = acc_step2;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        if (ctrl.advance) begin
            a_next = pin_a;
            b_next = pin_b;
            acc_next = ctrl.clear ? '0 : acc_step2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= 1'b0;
            b_reg <= 1'b0;
            acc_reg <= '0;
        end else begin
            a_reg <= a_next;
            b_reg <= b_next;
            acc_reg <= acc_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && ctrl.clear |=> acc_reg == '0)
        else $error("step count not cleared after report");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.advance |=> $stable(acc_reg) && $stable(a_reg) && $stable(b_reg))
        else $error("lane state changed without a request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && !ctrl.clear && pin_a == a_reg && pin_b == b_reg
        |=> $stable(acc_reg))
        else $error("step count moved without a pin edge");

endmodule
`default_nettype wire

@@ hw/rtl/qemr_shape.sv @@
// qemr_shape: doubles a step delta, clamps it to the limit and applies the gain
// depends on qemr_pkg
`default_nettype none
module qemr_shape
    import qemr_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire logic signed [ACCUM_WIDTH:0]  delta,
    input  wire shape_cfg_t                   cfg,
    output      logic signed [MOVE_WIDTH-1:0] move
);

    localparam int DW = ACCUM_WIDTH + 2;

    logic signed [DW-1:0]                     dbl;
    logic signed [DW-1:0]                     lim;
    logic signed [DW-1:0]                     clamped;
    logic signed [CLAMP_WIDTH+GAIN_WIDTH:0]   product;

    always_comb begin
        dbl = {delta, 1'b0};
        lim = $signed({{(DW-LIMIT_WIDTH){1'b0}}, cfg.limit});
        if (delta > 0) begin
            clamped = (dbl > lim) ? lim : dbl;
        end else begin
            clamped = (dbl < -lim) ? -lim : dbl;
        end
        product = $signed(clamped[CLAMP_WIDTH-1:0]) * $signed({1'b0, cfg.gain});
        move = product[MOVE_WIDTH-1:0];
    end

endmodule
`default_nettype wire

@@ hw/rtl/quadrature_encoder_mouse_report_unit.sv @@
// Quadrature encoder mouse report unit. Takes one pin sample per cycle (s_tready stays high
// unless a report is held back at the output); three decoder lanes update their step counts
// in the cycle the sample is accepted. A sample with report_tick set produces one report on
// the m_ channel: one register holds the lane counts, and the shaping stage (clamp and a
// 9x5 multiply per axis) feeds the output register. Back-pressure stalls the output register,
// and the capture register too once it holds a report; s_tready then follows m_tready.
// depends on qemr_pkg, qemr_lane, qemr_shape
`default_nettype none
module quadrature_encoder_mouse_report_unit
    import qemr_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // left_a, left_b, right_a, right_b, scroll_a, scroll_b, left_button, right_button,
    // report_tick, zero fill
    input  wire logic [S_DATA_WIDTH-1:0]   s_tdata,
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    // move_x, move_y, move_wheel, left_pressed, right_pressed, zero fill
    output      logic [M_DATA_WIDTH-1:0]   m_tdata,
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int LANES = 3;
    localparam int LANE_LEFT = 0;
    localparam int LANE_RIGHT = 1;
    localparam int LANE_SCROLL = 2;
    localparam int PAD_WIDTH = M_DATA_WIDTH - 3 * MOVE_WIDTH - 2;

    logic [LIMIT_WIDTH-1:0] limit_reg, limit_next;
    logic [GAIN_WIDTH-1:0]  pgain_reg, pgain_next;
    logic [GAIN_WIDTH-1:0]  wgain_reg, wgain_next;

    lane_ctrl_t                    lane_ctrl;
    logic signed [ACCUM_WIDTH-1:0] lane_count [LANES];

    logic                          st_valid_reg, st_valid_next;
    logic signed [ACCUM_WIDTH:0]   dx_reg, dx_next;
    logic signed [ACCUM_WIDTH:0]   dy_reg, dy_next;
    logic signed [ACCUM_WIDTH:0]   dw_reg, dw_next;
    logic                          lp_reg, lp_next;
    logic                          rp_reg, rp_next;

    logic                          m_valid_reg, m_valid_next;
    logic [M_DATA_WIDTH-1:0]       m_data_reg, m_data_next;

    logic signed [MOVE_WIDTH-1:0]  move_x, move_y, move_w;
    shape_cfg_t                    pointer_cfg, wheel_cfg;
    logic                          out_ready, st_ready, s_accept, tick;

    assign out_ready = !m_valid_reg || m_tready;
    assign st_ready  = !st_valid_reg || out_ready;
    assign s_tready  = st_ready;
    assign s_accept  = s_tvalid && st_ready;
    assign tick      = s_tdata[8];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign lane_ctrl.advance = s_accept;
    assign lane_ctrl.clear   = tick;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        qemr_lane #(
            .ACCUM_WIDTH(ACCUM_WIDTH)
        ) u_lane (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctrl   (lane_ctrl),
            .pin_a  (s_tdata[2*i]),
            .pin_b  (s_tdata[2*i+1]),
            .count  (lane_count[i])
        );
    end

    assign pointer_cfg.limit = limit_reg;
    assign pointer_cfg.gain  = pgain_reg;
    assign wheel_cfg.limit   = limit_reg;
    assign wheel_cfg.gain    = wgain_reg;

    qemr_shape #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_shape_x (
        .delta(dx_reg), .cfg(pointer_cfg), .move(move_x)
    );
    qemr_shape #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_shape_y (
        .delta(dy_reg), .cfg(pointer_cfg), .move(move_y)
    );
    qemr_shape #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_shape_w (
        .delta(dw_reg), .cfg(wheel_cfg), .move(move_w)
    );

    always_comb begin
        limit_next = limit_reg;
        pgain_next = pgain_reg;
        wgain_next = wgain_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ACCEL_LIMIT:  limit_next = cfg_data;
                REG_POINTER_GAIN: pgain_next = cfg_data[GAIN_WIDTH-1:0];
                REG_WHEEL_GAIN:   wgain_next = cfg_data[GAIN_WIDTH-1:0];
                default:          limit_next = limit_reg;
            endcase
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dw_next = dw_reg;
        lp_next = lp_reg;
        rp_next = rp_reg;
        if (st_ready) begin
            st_valid_next = s_accept && tick;
            dx_next = {lane_count[LANE_RIGHT][ACCUM_WIDTH-1], lane_count[LANE_RIGHT]};
            // left lane negated at full precision
            dy_next = -$signed({lane_count[LANE_LEFT][ACCUM_WIDTH-1], lane_count[LANE_LEFT]});
            dw_next = {lane_count[LANE_SCROLL][ACCUM_WIDTH-1], lane_count[LANE_SCROLL]};
            lp_next = !s_tdata[6];
            rp_next = !s_tdata[7];
        end
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        if (out_ready) begin
            m_valid_next = st_valid_reg;
            m_data_next = {{PAD_WIDTH{1'b0}}, rp_reg, lp_reg, move_w, move_y, move_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ACCEL_LIMIT_RST;
            pgain_reg <= POINTER_GAIN_RST;
            wgain_reg <= WHEEL_GAIN_RST;
            st_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg <= limit_next;
            pgain_reg <= pgain_next;
            wgain_reg <= wgain_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dw_reg <= dw_next;
        lp_reg <= lp_next;
        rp_reg <= rp_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && tick |=> st_valid_reg)
        else $error("report request lost at lane capture");

    assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && out_ready |=> m_valid_reg)
        else $error("captured report not moved to output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && !out_ready |=> st_valid_reg && $stable(dx_reg) && $stable(dy_reg))
        else $error("captured report overwritten while output stalled");

endmodule
`default_nettype wire

@@ sim/tb_quadrature_encoder_mouse_report_unit.sv @@
// testbench for quadrature_encoder_mouse_report_unit: drives pin samples, register writes and
// output back-pressure, and checks every report against an in-bench prediction of the lanes
// depends on qemr_pkg and quadrature_encoder_mouse_report_unit
`default_nettype none
module tb_quadrature_encoder_mouse_report_unit
    import qemr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_MAX = (1 << (ACCUM_WIDTH_DEF - 1)) - 1;
    localparam int COUNT_MIN = -COUNT_MAX - 1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int LANE_LEFT   = 0;
    localparam int LANE_RIGHT  = 1;
    localparam int LANE_SCROLL = 2;

    typedef struct packed {
        logic report_tick;
        logic right_button;
        logic left_button;
        logic scroll_b;
        logic scroll_a;
        logic right_b;
        logic right_a;
        logic left_b;
        logic left_a;
    } pin_sample_t;

    typedef struct {
        logic [MOVE_WIDTH-1:0] move_x;
        logic [MOVE_WIDTH-1:0] move_y;
        logic [MOVE_WIDTH-1:0] move_wheel;
        logic                  left_pressed;
        logic                  right_pressed;
    } mouse_report_t;

    class report_scoreboard;
        logic [LIMIT_WIDTH-1:0] accel_limit;
        logic [GAIN_WIDTH-1:0]  pointer_gain;
        logic [GAIN_WIDTH-1:0]  wheel_gain;
        bit                     level_a[3];
        bit                     level_b[3];
        int                     step_count[3];
        mouse_report_t          expected_reports[$];
        int                     errors;

        function new();
            accel_limit  = ACCEL_LIMIT_RST;
            pointer_gain = POINTER_GAIN_RST;
            wheel_gain   = WHEEL_GAIN_RST;
            errors       = 0;
            for (int i = 0; i < 3; i++) begin
                level_a[i]    = 1'b0;
                level_b[i]    = 1'b0;
                step_count[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_ACCEL_LIMIT: begin
                    accel_limit = data[LIMIT_WIDTH-1:0];
                end
                REG_POINTER_GAIN: begin
                    pointer_gain = data[GAIN_WIDTH-1:0];
                end
                REG_WHEEL_GAIN: begin
                    wheel_gain = data[GAIN_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [MOVE_WIDTH-1:0] shaped_move(int delta, int gain);
            int lim;
            int v;
            lim = int'(accel_limit);
            v = delta * 2;
            if (delta > 0) begin
                if (v > lim) v = lim;
            end else if (v < -lim) begin
                v = -lim;
            end
            v = v * gain;
            return v[MOVE_WIDTH-1:0];
        endfunction

        function void step_lane(int lane, bit a, bit b);
            if (a != level_a[lane]) begin
                level_a[lane] = !level_a[lane];
                if (level_a[lane] && !level_b[lane] && step_count[lane] < COUNT_MAX)
                    step_count[lane]++;
            end
            if (b != level_b[lane]) begin
                level_b[lane] = !level_b[lane];
                if (level_b[lane] && !level_a[lane] && step_count[lane] > COUNT_MIN)
                    step_count[lane]--;
            end
        endfunction

        function void note_sample(pin_sample_t s);
            mouse_report_t r;
            step_lane(LANE_LEFT, s.left_a, s.left_b);
            step_lane(LANE_RIGHT, s.right_a, s.right_b);
            step_lane(LANE_SCROLL, s.scroll_a, s.scroll_b);
            if (s.report_tick) begin
                r.move_x        = shaped_move(step_count[LANE_RIGHT], int'(pointer_gain));
                r.move_y        = shaped_move(-step_count[LANE_LEFT], int'(pointer_gain));
                r.move_wheel    = shaped_move(step_count[LANE_SCROLL], int'(wheel_gain));
                r.left_pressed  = !s.left_button;
                r.right_pressed = !s.right_button;
                expected_reports.push_back(r);
                for (int i = 0; i < 3; i++) step_count[i] = 0;
            end
        endfunction

        function void compare_field(string name, int exp_val, int act_val, bit bad);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0d, got %0d", name, exp_val, act_val);
            end
        endfunction

        function void check_report(logic [M_DATA_WIDTH-1:0] d);
            mouse_report_t e;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected report: m_tdata=%h", d);
                return;
            end
            e = expected_reports.pop_front();
            compare_field("move_x", $signed(e.move_x), $signed(d[12:0]), d[12:0] !== e.move_x);
            compare_field("move_y", $signed(e.move_y), $signed(d[25:13]),
                d[25:13] !== e.move_y);
            compare_field("move_wheel", $signed(e.move_wheel), $signed(d[38:26]),
                d[38:26] !== e.move_wheel);
            compare_field("left_pressed", int'(e.left_pressed), int'(d[39]),
                d[39] !== e.left_pressed);
            compare_field("right_pressed", int'(e.right_pressed), int'(d[40]),
                d[40] !== e.right_pressed);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic [S_DATA_WIDTH-1:0]   s_tdata   = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [M_DATA_WIDTH-1:0]   m_tdata;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    report_scoreboard sb = new();
    bit               calm = 1'b0;
    int               lane_pos[3] = '{0, 0, 0};
    int               lane_dir[3] = '{1, -1, 0};

    logic [7:0] fixed_settings [5][3] = '{
        '{8'd255, 8'h0F, 8'h0F},
        '{8'd1,   8'h01, 8'h01},
        '{8'd0,   8'h05, 8'h03},
        '{8'd40,  8'h00, 8'h00},
        '{8'd7,   8'hF3, 8'hA9}
    };

    pin_sample_t opening_samples [19] = '{
        9'b1_00_000000, 9'b1_11_000000, 9'b0_11_010101, 9'b1_10_010101,
        9'b0_11_111111, 9'b0_11_101010, 9'b0_11_000000, 9'b0_11_101010,
        9'b1_01_101010, 9'b0_11_010101, 9'b0_11_101010, 9'b0_11_010101,
        9'b0_11_000000, 9'b0_11_111111, 9'b1_11_000000, 9'b0_11_000001,
        9'b0_11_000100, 9'b0_11_100000, 9'b1_11_100000
    };

    quadrature_encoder_mouse_report_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    // output back-pressure
    initial begin
        forever begin
            if (!calm && aresetn && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12))
                @(posedge aclk);
        end
    end

    task automatic send_sample(pin_sample_t s);
        bit hit;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tdata  <= {{(S_DATA_WIDTH - 9){1'b0}}, s};
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            hit = s_tready;
            if (hit) sb.note_sample(s);
            @(posedge aclk);
        end while (!hit);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        bit hit;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do begin
            @(negedge aclk);
            hit = cfg_ready;
            if (hit) sb.write_reg(idx, data);
            @(posedge aclk);
        end while (!hit);
    endtask

    task automatic program_regs(logic [7:0] limit, logic [7:0] pgain, logic [7:0] wgain);
        write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        write_reg(REG_ACCEL_LIMIT, limit);
        write_reg(REG_POINTER_GAIN, pgain);
        write_reg(REG_WHEEL_GAIN, wgain);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // two samples per step on every lane at once, lanes start and end at both pins low
    task automatic spin_lanes(bit forward, int count);
        for (int i = 0; i < count; i++) begin
            send_sample(forward ? 9'b0_11_010101 : 9'b0_11_101010);
            send_sample(9'b0_11_000000);
        end
    endtask

    task automatic random_run(int count, int tick_div);
        logic [8:0] bits;
        logic [5:0] noise;
        logic [1:0] pos;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 2) begin
                noise = 6'($urandom);
                bits[5:0] = noise;
                for (int l = 0; l < 3; l++) begin
                    pos = {noise[2*l+1], noise[2*l] ^ noise[2*l+1]};
                    lane_pos[l] = int'(pos);
                end
            end else begin
                for (int l = 0; l < 3; l++) begin
                    if ($urandom_range(0, 15) == 0) lane_dir[l] = int'($urandom_range(0, 2)) - 1;
                    lane_pos[l] = (lane_pos[l] + lane_dir[l] + 4) % 4;
                    pos = 2'(lane_pos[l]);
                    bits[2*l]   = pos[1] ^ pos[0];
                    bits[2*l+1] = pos[1];
                end
            end
            bits[7:6] = 2'($urandom_range(0, 3));
            bits[8]   = ($urandom_range(0, tick_div - 1) == 0);
            send_sample(pin_sample_t'(bits));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_samples[i]) send_sample(opening_samples[i]);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 5)
                program_regs(fixed_settings[phase][0], fixed_settings[phase][1],
                    fixed_settings[phase][2]);
            else
                program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
            if (phase == 0) begin
                // steady spins in both directions, a report after each
                calm = 1'b1;
                send_sample(9'b0_11_000000);
                spin_lanes(1'b1, 40);
                send_sample(9'b1_11_000000);
                spin_lanes(1'b0, 40);
                send_sample(9'b1_11_000000);
                calm = 1'b0;
            end
            calm = (phase == 9);
            random_run(100, 2 + int'($urandom_range(0, 30)));
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/qemr_pkg.sv
hw/rtl/qemr_lane.sv
hw/rtl/qemr_shape.sv
hw/rtl/quadrature_encoder_mouse_report_unit.sv
sim/tb_quadrature_encoder_mouse_report_unit.sv
